// ===== rtl/core/psws_pkg.sv =====
// Shared constants and types of the partitioned sliding window sum.
package psws_pkg;

  localparam int unsigned WINDOW_DEPTH = 128;

  localparam int unsigned ROW_W    = 47;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SUM_W    = 39;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PREC_W   = 7;
  localparam int unsigned MOD_W    = 32;

  localparam int unsigned POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(ROW_W + 1);

  localparam logic [MOD_W-1:0]  DEFAULT_MODULUS  = MOD_W'(997);
  localparam logic [PREC_W-1:0] RESET_PRECEDING  = PREC_W'(5);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PRECEDING  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_MODULUS = CFG_IDX_W'(1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified row handed from front end to window update
  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
  } job_t;

  typedef struct packed {
    logic [PREC_W-1:0] window_preceding;
    logic [MOD_W-1:0]  partition_modulus;
    logic              clear_window;
  } cfg_t;

endpackage

// ===== rtl/core/psws_intf.sv =====
// Channel interfaces: row input, result output and configuration write.
interface psws_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [psws_pkg::ROW_W-1:0]             row_id;
  logic signed [psws_pkg::SAMPLE_W-1:0]   sample_value;
  logic                                   start_of_scan;

  modport source (output valid, row_id, sample_value, start_of_scan, input ready);
  modport sink   (input valid, row_id, sample_value, start_of_scan, output ready);
endinterface

interface psws_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psws_pkg::SUM_W-1:0]   window_sum;
  logic [psws_pkg::KEY_W-1:0]          partition_key;

  modport source (output valid, window_sum, partition_key, input ready);
  modport sink   (input valid, window_sum, partition_key, output ready);
endinterface

interface psws_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [psws_pkg::CFG_IDX_W-1:0]      index;
  logic [psws_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/partitioned_sliding_window_sum_top.sv =====
// Top level of the partitioned sliding window sum.
// Usage:
//   in_i  : one transaction per row (row_id, sample_value, start_of_scan).
//   out_o : one transaction per row (window_sum, partition_key), in order.
//   cfg_i : register writes; index 0 window_preceding, index 1
//           partition_modulus. Writing window_preceding empties the window.
//           Always ready; write only while no row is in flight.
// Rows: the front end takes a new row only once it has finished the 47-step
// bit-serial remainder of the previous row id and handed that row on; a row
// id of zero skips the remainder. The ring update behind the queue takes one
// row per cycle while the output register is free.
// Reset: window_preceding 5, partition_modulus 997, window empty, previous
// key zero. Ring contents are not cleared; fill count tracks valid slots.
// Stall: a result waits in the output register while out_o.ready is low;
// the queue and front end keep accepting until both fill, then in_i.ready
// stays low.
module partitioned_sliding_window_sum_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  psws_in_if.sink  in_i,
  psws_out_if.source out_o,
  psws_cfg_if.sink cfg_i
);

  logic [psws_pkg::PREC_W-1:0] preceding_q;
  logic [psws_pkg::MOD_W-1:0]  modulus_q;
  logic                        cfg_fire;
  psws_pkg::cfg_t              cfg;

  logic           f_valid, f_ready, q_valid, q_ready;
  psws_pkg::job_t f_job, q_job;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preceding_q <= psws_pkg::RESET_PRECEDING;
      modulus_q   <= psws_pkg::DEFAULT_MODULUS;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        psws_pkg::REG_WINDOW_PRECEDING:  preceding_q <= cfg_i.data[psws_pkg::PREC_W-1:0];
        psws_pkg::REG_PARTITION_MODULUS: modulus_q   <= cfg_i.data[psws_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.window_preceding  = preceding_q;
  assign cfg.partition_modulus = modulus_q;
  assign cfg.clear_window      = cfg_fire && (cfg_i.index == psws_pkg::REG_WINDOW_PRECEDING);

  psws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .modulus_i   (cfg.partition_modulus),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  psws_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  psws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .cfg_i       (cfg),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/psws_front.sv =====
// Front end: accepts rows and derives the partition key by bit-serial remainder.
module psws_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  psws_in_if.sink                in_i,
  input  logic [psws_pkg::MOD_W-1:0] modulus_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output psws_pkg::job_t         job_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [psws_pkg::ROW_W-1:0]       dividend_q;
  logic [psws_pkg::MOD_W-1:0]       rem_q;
  logic [psws_pkg::MOD_W-1:0]       modulus_q;
  logic [psws_pkg::CNT_W-1:0]       cnt_q;
  logic                             zero_q;
  logic signed [psws_pkg::SAMPLE_W-1:0] sample_q;
  logic                             start_q;

  logic                             in_fire;
  logic [psws_pkg::MOD_W:0]         trial;
  logic [psws_pkg::MOD_W-1:0]       rem_step;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // one quotient bit per cycle; remainder always stays below the modulus
  always_comb begin
    trial = {rem_q, dividend_q[psws_pkg::ROW_W-1]};
    if (trial >= {1'b0, modulus_q}) begin
      rem_step = psws_pkg::MOD_W'(trial - {1'b0, modulus_q});
    end else begin
      rem_step = trial[psws_pkg::MOD_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.row_id == '0) ? ST_PUSH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == psws_pkg::CNT_W'(1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (job_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= psws_pkg::CNT_W'(psws_pkg::ROW_W);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - psws_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dividend_q <= in_i.row_id - psws_pkg::ROW_W'(1);
      rem_q      <= '0;
      modulus_q  <= (modulus_i == '0) ? psws_pkg::DEFAULT_MODULUS : modulus_i;
      zero_q     <= (in_i.row_id == '0);
      sample_q   <= in_i.sample_value;
      start_q    <= in_i.start_of_scan;
    end else if (state_q == ST_DIV) begin
      rem_q      <= rem_step;
      dividend_q <= {dividend_q[psws_pkg::ROW_W-2:0], 1'b0};
    end
  end

  assign job_valid_o  = (state_q == ST_PUSH);
  assign job_o.key    = zero_q ? '0 : rem_q + psws_pkg::KEY_W'(1);
  assign job_o.sample = sample_q;
  assign job_o.start  = start_q;

endmodule

// ===== rtl/core/psws_queue.sv =====
// Short queue between front end and window update.
module psws_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  psws_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output psws_pkg::job_t pop_data_o
);

  psws_pkg::job_t                  entries_q [psws_pkg::QUEUE_DEPTH];
  logic [psws_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [psws_pkg::QCNT_W-1:0]     count_q;
  logic                            push, pop;

  assign push_ready_o = (count_q != psws_pkg::QCNT_W'(psws_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rptr_q];

  function automatic logic [psws_pkg::QPTR_W-1:0] next_ptr(
    input logic [psws_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == psws_pkg::QPTR_W'(psws_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + psws_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + psws_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - psws_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/psws_back.sv =====
// Back end: ring buffer update, running sum and result register.
module psws_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  psws_pkg::job_t job_i,
  input  psws_pkg::cfg_t cfg_i,
  psws_out_if.source     out_o
);

  logic signed [psws_pkg::SAMPLE_W-1:0] store_q [psws_pkg::WINDOW_DEPTH];
  logic signed [psws_pkg::SAMPLE_W-1:0] rdata_q;

  logic [psws_pkg::FILL_W-1:0]  fill_q;
  logic [psws_pkg::POS_W-1:0]   oldest_q;
  logic [psws_pkg::KEY_W-1:0]   prev_key_q;
  logic signed [psws_pkg::SUM_W-1:0] sum_q;

  logic                         b_valid_q;
  logic signed [psws_pkg::SAMPLE_W-1:0] b_amt_q;
  logic                         b_replace_q;
  logic                         b_clear_q;
  logic [psws_pkg::KEY_W-1:0]   b_key_q;

  logic                         out_valid_q;
  logic signed [psws_pkg::SUM_W-1:0] out_sum_q;
  logic [psws_pkg::KEY_W-1:0]   out_key_q;

  logic [psws_pkg::PREC_W:0]    width_raw;
  logic [psws_pkg::FILL_W-1:0]  width;
  logic                         out_free, b_adv, a_fire, a_clear, append;
  logic [psws_pkg::FILL_W-1:0]  fill_eff, old_eff, old_inc;
  logic [psws_pkg::FILL_W-1:0]  fill_d, oldest_d;
  logic [psws_pkg::POS_W-1:0]   addr;
  logic signed [psws_pkg::SUM_W-1:0] base, amt_ext, old_ext, sum_new;

  always_comb begin
    width_raw = {1'b0, cfg_i.window_preceding} + (psws_pkg::PREC_W + 1)'(1);
    if (32'(width_raw) > 32'(psws_pkg::WINDOW_DEPTH)) begin
      width = psws_pkg::FILL_W'(psws_pkg::WINDOW_DEPTH);
    end else begin
      width = psws_pkg::FILL_W'(width_raw);
    end
  end

  assign out_free    = !out_valid_q || out_o.ready;
  assign b_adv       = b_valid_q && out_free;
  assign job_ready_o = !b_valid_q || b_adv;
  assign a_fire      = job_valid_i && job_ready_o;

  // issue stage: decide append or replace, address the ring
  always_comb begin
    a_clear  = job_i.start || (job_i.key != prev_key_q);
    fill_eff = a_clear ? '0 : fill_q;
    old_eff  = a_clear ? '0 : psws_pkg::FILL_W'(oldest_q);
    if (old_eff >= width) begin
      old_eff = '0;
    end
    append  = (fill_eff < width);
    old_inc = old_eff + psws_pkg::FILL_W'(1);
    if (append) begin
      addr     = fill_eff[psws_pkg::POS_W-1:0];
      fill_d   = fill_eff + psws_pkg::FILL_W'(1);
      oldest_d = old_eff;
    end else begin
      addr     = old_eff[psws_pkg::POS_W-1:0];
      fill_d   = fill_eff;
      oldest_d = (old_inc == width) ? '0 : old_inc;
    end
  end

  // read-first: a replace sees the amount it overwrites
  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      store_q[addr] <= job_i.sample;
      rdata_q       <= store_q[addr];
    end
  end

  always_comb begin
    base    = b_clear_q ? '0 : sum_q;
    amt_ext = {{(psws_pkg::SUM_W - psws_pkg::SAMPLE_W){b_amt_q[psws_pkg::SAMPLE_W-1]}},
               b_amt_q};
    old_ext = b_replace_q
              ? {{(psws_pkg::SUM_W - psws_pkg::SAMPLE_W){rdata_q[psws_pkg::SAMPLE_W-1]}},
                 rdata_q}
              : '0;
    sum_new = base + amt_ext - old_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      oldest_q    <= '0;
      prev_key_q  <= '0;
      sum_q       <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.clear_window) begin
        fill_q   <= '0;
        oldest_q <= '0;
        sum_q    <= '0;
      end else begin
        if (a_fire) begin
          fill_q   <= fill_d;
          oldest_q <= oldest_d[psws_pkg::POS_W-1:0];
        end
        if (b_adv) begin
          sum_q <= sum_new;
        end
      end
      if (a_fire) begin
        prev_key_q <= job_i.key;
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_amt_q     <= job_i.sample;
      b_replace_q <= !append;
      b_clear_q   <= a_clear;
      b_key_q     <= job_i.key;
    end
    if (b_adv) begin
      out_sum_q <= sum_new;
      out_key_q <= b_key_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.window_sum    = out_sum_q;
  assign out_o.partition_key = out_key_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= width)
    else $error("fill count beyond window width");

  a_oldest_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> (fill_q == width))
    else $error("ring pointer moved before window filled");

  a_full_stays_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && !a_clear && !cfg_i.clear_window && fill_q == width) |=> (fill_q == width))
    else $error("full window lost entries without a clear");

endmodule
